// ===== src/hmt_pkg.sv =====
// shared types, constants and register map for the heartbeat membership table
package hmt_pkg;

    // default table sizes
    localparam int MEMBER_SLOTS_DEF  = 32;
    localparam int SUSPECT_SLOTS_DEF = 32;

    // most results reported for one input transaction
    localparam int MAX_RESULTS = 64;
    localparam int EVC_W       = $clog2(MAX_RESULTS + 1);

    // configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_SELF_ID     = 3'd0;
    localparam logic [2:0] REG_SELF_PORT   = 3'd1;
    localparam logic [2:0] REG_FAIL_TIME   = 3'd2;
    localparam logic [2:0] REG_REMOVE_TIME = 3'd3;
    localparam logic [2:0] REG_INTRODUCER  = 3'd4;

    // input kinds
    localparam logic [1:0] KIND_GOSSIP = 2'd0;
    localparam logic [1:0] KIND_JOIN   = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // result events
    localparam logic [2:0] EV_ADDED     = 3'd0;
    localparam logic [2:0] EV_REFRESHED = 3'd1;
    localparam logic [2:0] EV_SUSPECTED = 3'd2;
    localparam logic [2:0] EV_REMOVED   = 3'd3;
    localparam logic [2:0] EV_DROPPED   = 3'd4;

    // one member table entry
    typedef struct packed {
        logic        vld;
        logic [31:0] node;
        logic [15:0] port;
        logic [31:0] beat;
        logic [31:0] stamp;
    } mem_ent_t;

    // one suspect list entry
    typedef struct packed {
        logic        vld;
        logic [31:0] node;
        logic [15:0] port;
        logic [31:0] stamp;
    } sus_ent_t;

    // per-cell control
    typedef struct packed {
        logic shift;
        logic wr;
    } cell_ctl_t;

endpackage

// ===== src/heartbeat_membership_table.sv =====
// top level: member ring, suspect ring, transfer queue and sequencer
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  item     | item_valid/stall    | kind, entry_id, entry_port, entry_heartbeat,
//           |                     | end_of_message
//  result   | res_valid/stall     | event_res, node_id, node_port,
//           |                     | node_heartbeat, last
//  config   | apb psel/penable    | paddr, pwdata, prdata
//
// gossip and join entries scan both rings, then rotate the member ring once to write;
// a tick sweeps the member ring, then the suspect ring, when joined or introducer, and
// goes straight to flush otherwise; each ring moves one cell a cycle, but
// result stalls freeze the tick sweep; a finished result waits in the output
// register while the next transaction is accepted
// reset clears all valid bits, local time and the joined flag at once
module heartbeat_membership_table #(
    parameter int MEMBER_SLOTS  = hmt_pkg::MEMBER_SLOTS_DEF,
    parameter int SUSPECT_SLOTS = hmt_pkg::SUSPECT_SLOTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hmt_pkg::APB_AW-1:0] paddr,
    input  logic [hmt_pkg::APB_DW-1:0] pwdata,
    output logic [hmt_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    // items
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [1:0]                 kind,
    input  logic [31:0]                entry_id,
    input  logic [15:0]                entry_port,
    input  logic [31:0]                entry_heartbeat,
    input  logic                       end_of_message,
    // results
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic [2:0]                 event_res,
    output logic [31:0]                node_id,
    output logic [15:0]                node_port,
    output logic [31:0]                node_heartbeat,
    output logic                       last
);
    import hmt_pkg::*;

    localparam int MIW  = $clog2(MEMBER_SLOTS);
    localparam int SIW  = $clog2(SUSPECT_SLOTS);
    localparam int OCW  = $clog2(SUSPECT_SLOTS + 1);
    localparam int LMAX = (MEMBER_SLOTS > SUSPECT_SLOTS) ? MEMBER_SLOTS : SUSPECT_SLOTS;
    localparam int CW   = $clog2(LMAX + 1);
    localparam logic [CW-1:0]  M_CNT  = CW'(MEMBER_SLOTS);
    localparam logic [CW-1:0]  S_CNT  = CW'(SUSPECT_SLOTS);
    localparam logic [CW-1:0]  M_LAST = CW'(MEMBER_SLOTS - 1);
    localparam logic [CW-1:0]  S_LAST = CW'(SUSPECT_SLOTS - 1);
    localparam logic [CW-1:0]  L_LAST = CW'(LMAX - 1);
    localparam logic [OCW-1:0] S_OCC  = OCW'(SUSPECT_SLOTS);
    localparam logic [EVC_W-1:0] EV_MAX = EVC_W'(MAX_RESULTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_TICK_M,
        ST_TICK_S,
        ST_FLUSH
    } state_t;

    // configuration registers
    logic [31:0] self_id_reg;
    logic [15:0] self_port_reg;
    logic [15:0] fail_time_reg;
    logic [15:0] remove_time_reg;
    logic        intro_reg;

    // block state
    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    logic [31:0]     local_time_reg;
    logic            joined_reg;
    logic [OCW-1:0]  occ_reg;
    logic [OCW-1:0]  xq_cnt_reg;
    logic [EVC_W-1:0] ev_cnt_reg;

    // latched item
    logic [1:0]  kind_reg;
    logic [31:0] id_reg;
    logic [15:0] port_reg;
    logic [31:0] beat_reg;

    // scan findings
    logic           sus_hit_reg;
    logic           mem_hit_reg;
    logic           newer_reg;
    logic [MIW-1:0] hit_idx_reg;
    logic           free_found_reg;
    logic [MIW-1:0] free_idx_reg;

    // held result and output register
    logic        hold_valid_reg;
    logic [2:0]  hold_ev_reg;
    logic [31:0] hold_id_reg;
    logic [15:0] hold_port_reg;
    logic [31:0] hold_beat_reg;
    logic        res_valid_reg;
    logic [2:0]  res_ev_reg;
    logic [31:0] res_id_reg;
    logic [15:0] res_port_reg;
    logic [31:0] res_beat_reg;
    logic        res_last_reg;

    // ring wiring
    mem_ent_t  m_q [MEMBER_SLOTS];
    sus_ent_t  s_q [SUSPECT_SLOTS];
    sus_ent_t  x_q [SUSPECT_SLOTS];
    mem_ent_t  m_head;
    mem_ent_t  m_tail;
    sus_ent_t  s_head;
    sus_ent_t  s_tail;
    sus_ent_t  s_work;
    sus_ent_t  xq_wdata;
    logic      m_shift;
    logic      s_shift;
    logic      xq_push;
    logic      xq_pop;

    // control decode
    logic           en;
    logic           accept;
    logic           cfg_wr;
    logic           res_load;
    logic           is_self;
    logic           do_ins;
    logic           do_ref;
    logic           do_write;
    logic [MIW-1:0] tgt_idx;
    logic           m_stale;
    logic           s_expired;
    logic           gen;
    logic           gen_ok;
    logic [2:0]     gen_ev;
    logic [31:0]    gen_id;
    logic [15:0]    gen_port;
    logic [31:0]    gen_beat;

    assign m_head = m_q[0];
    assign s_head = s_q[0];

    // member ring
    for (genvar k = 0; k < MEMBER_SLOTS; k++)
    begin : g_mem
        mem_ent_t nb;
        if (k == MEMBER_SLOTS - 1)
        begin : g_tail
            assign nb = m_tail;
        end
        else
        begin : g_mid
            assign nb = m_q[k + 1];
        end
        hmt_member_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (m_shift),
            .shift_in (nb),
            .ent      (m_q[k])
        );
    end

    // suspect ring and transfer queue
    for (genvar k = 0; k < SUSPECT_SLOTS; k++)
    begin : g_sus
        sus_ent_t  nb;
        sus_ent_t  xnb;
        cell_ctl_t s_ctl;
        cell_ctl_t x_ctl;
        if (k == SUSPECT_SLOTS - 1)
        begin : g_tail
            assign nb  = s_tail;
            assign xnb = '0;
        end
        else
        begin : g_mid
            assign nb  = s_q[k + 1];
            assign xnb = x_q[k + 1];
        end
        assign s_ctl = '{shift: s_shift, wr: 1'b0};
        assign x_ctl = '{shift: xq_pop, wr: xq_push && (xq_cnt_reg == OCW'(k))};
        hmt_suspect_cell u_ring (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (s_ctl),
            .shift_in (nb),
            .wr_data  (xq_wdata),
            .ent      (s_q[k])
        );
        hmt_suspect_cell u_xq (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (x_ctl),
            .shift_in (xnb),
            .wr_data  (xq_wdata),
            .ent      (x_q[k])
        );
    end

    // handshakes
    assign en         = !res_valid_reg || !res_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && (state_reg == ST_IDLE);
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;

    // output register takes the held result this cycle
    assign res_load   = hold_valid_reg && (gen_ok || (state_reg == ST_FLUSH && en));

    // entry decision after the scan
    always_comb
    begin
        is_self  = (id_reg == self_id_reg) && (port_reg == self_port_reg);
        do_ins   = !is_self && !mem_hit_reg &&
                   ((kind_reg == KIND_GOSSIP && !sus_hit_reg) || kind_reg == KIND_JOIN);
        do_ref   = (kind_reg == KIND_GOSSIP) && !is_self && !sus_hit_reg &&
                   mem_hit_reg && newer_reg;
        do_write = (do_ins && free_found_reg) || do_ref;
        tgt_idx  = do_ref ? hit_idx_reg : free_idx_reg;
    end

    // sweep compares, done without wrap
    assign m_stale = m_head.vld &&
                     (({1'b0, m_head.stamp} + {17'b0, fail_time_reg}) <
                      {1'b0, local_time_reg});

    always_comb
    begin
        s_work = s_head;
        if (!s_head.vld && xq_cnt_reg != '0)
        begin
            s_work = x_q[0];
            s_work.vld = 1'b1;
        end
    end

    assign s_expired = s_work.vld &&
                       (({1'b0, s_work.stamp} + {17'b0, remove_time_reg}) <
                        {1'b0, local_time_reg});

    // ring steering and result generation
    always_comb
    begin
        m_shift  = 1'b0;
        m_tail   = m_head;
        s_shift  = 1'b0;
        s_tail   = s_head;
        xq_push  = 1'b0;
        xq_pop   = 1'b0;
        xq_wdata = '{vld: 1'b1, node: m_head.node, port: m_head.port, stamp: m_head.stamp};
        gen      = 1'b0;
        gen_ev   = EV_ADDED;
        gen_id   = id_reg;
        gen_port = port_reg;
        gen_beat = beat_reg;
        unique case (state_reg)
            ST_SCAN:
            begin
                m_shift = (cnt_reg < M_CNT);
                s_shift = (cnt_reg < S_CNT);
            end
            ST_APPLY:
            begin
                m_shift = 1'b1;
                if (do_write && cnt_reg[MIW-1:0] == tgt_idx)
                begin
                    m_tail = '{vld: 1'b1, node: id_reg, port: port_reg,
                               beat: beat_reg, stamp: local_time_reg};
                end
                gen    = (cnt_reg == '0) && (do_ins || do_ref);
                gen_ev = do_ref ? EV_REFRESHED : (free_found_reg ? EV_ADDED : EV_DROPPED);
            end
            ST_TICK_M:
            begin
                m_shift  = en;
                gen      = en && m_stale;
                gen_id   = m_head.node;
                gen_port = m_head.port;
                gen_beat = m_head.beat;
                if (m_stale)
                begin
                    m_tail.vld = 1'b0;
                end
                if (occ_reg < S_OCC)
                begin
                    gen_ev  = EV_SUSPECTED;
                    xq_push = en && m_stale;
                end
                else
                begin
                    gen_ev = EV_DROPPED;
                end
            end
            ST_TICK_S:
            begin
                s_shift  = en;
                xq_pop   = en && !s_head.vld && (xq_cnt_reg != '0);
                s_tail   = s_work;
                gen      = en && s_expired;
                gen_ev   = EV_REMOVED;
                gen_id   = s_work.node;
                gen_port = s_work.port;
                gen_beat = '0;
                if (s_expired)
                begin
                    s_tail.vld = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        gen_ok = gen && (ev_cnt_reg < EV_MAX);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg     <= '0;
            self_port_reg   <= '0;
            fail_time_reg   <= 16'd5;
            remove_time_reg <= 16'd20;
            intro_reg       <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_SELF_ID:     self_id_reg     <= pwdata;
                REG_SELF_PORT:   self_port_reg   <= pwdata[15:0];
                REG_FAIL_TIME:   fail_time_reg   <= pwdata[15:0];
                REG_REMOVE_TIME: remove_time_reg <= pwdata[15:0];
                REG_INTRODUCER:  intro_reg       <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[4:2])
            REG_SELF_ID:     prdata = self_id_reg;
            REG_SELF_PORT:   prdata = {16'b0, self_port_reg};
            REG_FAIL_TIME:   prdata = {16'b0, fail_time_reg};
            REG_REMOVE_TIME: prdata = {16'b0, remove_time_reg};
            REG_INTRODUCER:  prdata = {31'b0, intro_reg};
            default:         prdata = '0;
        endcase
    end

    // sequencer, counters and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            local_time_reg <= '0;
            joined_reg     <= 1'b0;
            occ_reg        <= '0;
            xq_cnt_reg     <= '0;
            ev_cnt_reg     <= '0;
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            // output register drains
            if (res_valid_reg && !res_stall && !res_load)
            begin
                res_valid_reg <= 1'b0;
            end

            // new result: previous held one goes out
            if (gen_ok)
            begin
                if (hold_valid_reg)
                begin
                    res_valid_reg <= 1'b1;
                    res_ev_reg    <= hold_ev_reg;
                    res_id_reg    <= hold_id_reg;
                    res_port_reg  <= hold_port_reg;
                    res_beat_reg  <= hold_beat_reg;
                    res_last_reg  <= 1'b0;
                end
                hold_valid_reg <= 1'b1;
                hold_ev_reg    <= gen_ev;
                hold_id_reg    <= gen_id;
                hold_port_reg  <= gen_port;
                hold_beat_reg  <= gen_beat;
                ev_cnt_reg     <= ev_cnt_reg + 1'b1;
            end

            // suspect occupancy and transfer queue
            if (xq_push)
            begin
                xq_cnt_reg <= xq_cnt_reg + 1'b1;
                occ_reg    <= occ_reg + 1'b1;
            end
            else if (xq_pop)
            begin
                xq_cnt_reg <= xq_cnt_reg - 1'b1;
                if (s_expired)
                begin
                    occ_reg <= occ_reg - 1'b1;
                end
            end
            else if (state_reg == ST_TICK_S && en && s_expired)
            begin
                occ_reg <= occ_reg - 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg       <= kind;
                        id_reg         <= entry_id;
                        port_reg       <= entry_port;
                        beat_reg       <= entry_heartbeat;
                        cnt_reg        <= '0;
                        ev_cnt_reg     <= '0;
                        sus_hit_reg    <= 1'b0;
                        mem_hit_reg    <= 1'b0;
                        newer_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        if (kind == KIND_GOSSIP || kind == KIND_JOIN)
                        begin
                            state_reg <= ST_SCAN;
                            if (kind == KIND_JOIN && end_of_message)
                            begin
                                joined_reg <= 1'b1;
                            end
                        end
                        else if (kind == KIND_TICK)
                        begin
                            local_time_reg <= local_time_reg + 1'b1;
                            state_reg <= (joined_reg || intro_reg) ? ST_TICK_M : ST_FLUSH;
                        end
                        else
                        begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (m_shift)
                    begin
                        if (m_head.vld && m_head.node == id_reg && m_head.port == port_reg)
                        begin
                            mem_hit_reg <= 1'b1;
                            hit_idx_reg <= cnt_reg[MIW-1:0];
                            newer_reg   <= (beat_reg > m_head.beat);
                        end
                        if (!m_head.vld && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= cnt_reg[MIW-1:0];
                        end
                    end
                    if (s_shift && s_head.vld && s_head.node == id_reg &&
                        s_head.port == port_reg)
                    begin
                        sus_hit_reg <= 1'b1;
                    end
                    if (cnt_reg == L_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_APPLY;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_APPLY:
                begin
                    if (cnt_reg == M_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FLUSH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_TICK_M:
                begin
                    if (en)
                    begin
                        if (cnt_reg == M_LAST)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= ST_TICK_S;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                ST_TICK_S:
                begin
                    if (en)
                    begin
                        if (cnt_reg == S_LAST)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (!hold_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (en)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_ev_reg     <= hold_ev_reg;
                        res_id_reg     <= hold_id_reg;
                        res_port_reg   <= hold_port_reg;
                        res_beat_reg   <= hold_beat_reg;
                        res_last_reg   <= 1'b1;
                        hold_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid      = res_valid_reg;
    assign event_res      = res_ev_reg;
    assign node_id        = res_id_reg;
    assign node_port      = res_port_reg;
    assign node_heartbeat = res_beat_reg;
    assign last           = res_last_reg;

`ifndef SYNTHESIS
    // suspect occupancy never exceeds the list size
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= S_OCC)
        else $error("suspect occupancy overflow");

    // queued transfers are part of the occupancy count
    a_xq_in_occ: assert property (@(posedge clk) disable iff (!rst_n)
        xq_cnt_reg <= occ_reg)
        else $error("transfer queue exceeds occupancy");

    // the transfer queue is empty once a sweep is over
    a_xq_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (xq_cnt_reg == '0))
        else $error("transfer queue not drained");

    // no held result survives into idle
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("result left behind in idle");
`endif

endmodule

// ===== src/hmt_member_cell.sv =====
// one member table cell, hands its entry to the lower neighbor on shift
module hmt_member_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  hmt_pkg::mem_ent_t shift_in,
    output hmt_pkg::mem_ent_t ent
);
    import hmt_pkg::*;

    logic        vld_reg;
    logic [31:0] node_reg;
    logic [15:0] port_reg;
    logic [31:0] beat_reg;
    logic [31:0] stamp_reg;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (shift)
        begin
            vld_reg <= shift_in.vld;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            node_reg  <= shift_in.node;
            port_reg  <= shift_in.port;
            beat_reg  <= shift_in.beat;
            stamp_reg <= shift_in.stamp;
        end
    end

    assign ent = '{vld: vld_reg, node: node_reg, port: port_reg,
                   beat: beat_reg, stamp: stamp_reg};

endmodule

// ===== src/hmt_suspect_cell.sv =====
// one suspect cell, shifts from its neighbor or takes a direct write
module hmt_suspect_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  hmt_pkg::cell_ctl_t ctl,
    input  hmt_pkg::sus_ent_t  shift_in,
    input  hmt_pkg::sus_ent_t  wr_data,
    output hmt_pkg::sus_ent_t  ent
);
    import hmt_pkg::*;

    sus_ent_t src;
    logic        vld_reg;
    logic [31:0] node_reg;
    logic [15:0] port_reg;
    logic [31:0] stamp_reg;

    assign src = ctl.wr ? wr_data : shift_in;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.shift || ctl.wr)
        begin
            vld_reg <= src.vld;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctl.shift || ctl.wr)
        begin
            node_reg  <= src.node;
            port_reg  <= src.port;
            stamp_reg <= src.stamp;
        end
    end

    assign ent = '{vld: vld_reg, node: node_reg, port: port_reg, stamp: stamp_reg};

endmodule

// ===== tb/tb_top.sv =====
// testbench for the heartbeat membership table: random and directed entries, predicted events
`timescale 1ns / 1ps

module tb_top;
    import hmt_pkg::*;

    localparam int MSLOTS = 32;
    localparam int SSLOTS = 32;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] beat;
        logic        eom;
    } entry_t;

    typedef struct packed {
        logic [2:0]  ev;
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] beat;
        logic        last;
    } event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [1:0] kind = '0;
    logic [31:0] entry_id = '0;
    logic [15:0] entry_port = '0;
    logic [31:0] entry_heartbeat = '0;
    logic end_of_message = 1'b0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic [2:0] event_res;
    logic [31:0] node_id;
    logic [15:0] node_port;
    logic [31:0] node_heartbeat;
    logic last;

    heartbeat_membership_table u_top (.*);

    always #1 clk = ~clk;

    // predictor state
    logic [31:0] cf_self_id;
    logic [15:0] cf_self_port;
    logic [15:0] cf_fail, cf_remove;
    logic        cf_intro;
    logic        m_vld [MSLOTS];
    logic [31:0] m_node [MSLOTS];
    logic [15:0] m_port [MSLOTS];
    logic [31:0] m_beat [MSLOTS];
    logic [31:0] m_stamp [MSLOTS];
    logic        s_vld [SSLOTS];
    logic [31:0] s_node [SSLOTS];
    logic [15:0] s_port [SSLOTS];
    logic [31:0] s_stamp [SSLOTS];
    logic [31:0] now;
    logic        has_joined;

    entry_t pending_entries[$];
    event_t expected_events[$];
    int errors = 0;
    int cycles = 0;
    int idle_pct = 0, stall_pct = 0;
    bit hold_results = 1'b0;

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    // append one entry to the pending queue
    function automatic void queue_entry(input entry_t it);
        pending_entries.insert(pending_entries.size(), it);
    endfunction

    function automatic void push_event(ref event_t evs[$], input logic [2:0] ev,
                                       input logic [31:0] id, input logic [15:0] port,
                                       input logic [31:0] beat);
        event_t e;
        if (evs.size() >= MAX_RESULTS) return;
        e = '{ev, id, port, beat, 1'b0};
        evs.insert(evs.size(), e);
    endfunction

    function automatic void add_member(ref event_t evs[$], input entry_t it);
        for (int i = 0; i < MSLOTS; i++)
            if (!m_vld[i])
            begin
                m_vld[i] = 1'b1; m_node[i] = it.id; m_port[i] = it.port;
                m_beat[i] = it.beat; m_stamp[i] = now;
                push_event(evs, EV_ADDED, it.id, it.port, it.beat);
                return;
            end
        push_event(evs, EV_DROPPED, it.id, it.port, it.beat);
    endfunction

    // compute events caused by one accepted entry
    function automatic void predict_entry(input entry_t it);
        event_t evs[$];
        int mi, si, slot;
        logic self_hit;
        self_hit = (it.id == cf_self_id) && (it.port == cf_self_port);
        mi = -1; si = -1;
        for (int i = 0; i < MSLOTS; i++)
            if (mi < 0 && m_vld[i] && m_node[i] == it.id && m_port[i] == it.port) mi = i;
        for (int j = 0; j < SSLOTS; j++)
            if (si < 0 && s_vld[j] && s_node[j] == it.id && s_port[j] == it.port) si = j;
        if (it.kind == KIND_GOSSIP)
        begin
            if (!self_hit && si < 0)
            begin
                if (mi < 0) add_member(evs, it);
                else if (it.beat > m_beat[mi])
                begin
                    m_beat[mi] = it.beat; m_stamp[mi] = now;
                    push_event(evs, EV_REFRESHED, it.id, it.port, it.beat);
                end
            end
        end
        else if (it.kind == KIND_JOIN)
        begin
            if (!self_hit && mi < 0) add_member(evs, it);
            if (it.eom) has_joined = 1'b1;
        end
        else if (it.kind == KIND_TICK)
        begin
            now = now + 32'd1;
            if (has_joined || cf_intro)
            begin
                for (int i = 0; i < MSLOTS; i++)
                    if (m_vld[i] && ({1'b0, m_stamp[i]} + cf_fail) < {1'b0, now})
                    begin
                        m_vld[i] = 1'b0;
                        slot = -1;
                        for (int j = 0; j < SSLOTS; j++)
                            if (slot < 0 && !s_vld[j]) slot = j;
                        if (slot < 0)
                            push_event(evs, EV_DROPPED, m_node[i], m_port[i], m_beat[i]);
                        else
                        begin
                            s_vld[slot] = 1'b1; s_node[slot] = m_node[i];
                            s_port[slot] = m_port[i]; s_stamp[slot] = m_stamp[i];
                            push_event(evs, EV_SUSPECTED, m_node[i], m_port[i], m_beat[i]);
                        end
                    end
                for (int j = 0; j < SSLOTS; j++)
                    if (s_vld[j] && ({1'b0, s_stamp[j]} + cf_remove) < {1'b0, now})
                    begin
                        s_vld[j] = 1'b0;
                        push_event(evs, EV_REMOVED, s_node[j], s_port[j], 32'd0);
                    end
            end
        end
        if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
        foreach (evs[k]) expected_events.insert(expected_events.size(), evs[k]);
    endfunction

    // driver: offers pending entries, predicts on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                predict_entry('{kind, entry_id, entry_port, entry_heartbeat, end_of_message});
            if (!item_valid || !item_stall)
            begin
                if (pending_entries.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    entry_t it;
                    it = pending_entries.pop_front();
                    item_valid <= 1'b1;
                    kind <= it.kind; entry_id <= it.id; entry_port <= it.port;
                    entry_heartbeat <= it.beat; end_of_message <= it.eom;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each result with the oldest expected event
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_events.size() == 0)
                    report($sformatf("unexpected event %0d id %h", event_res, node_id));
                else
                begin
                    event_t e;
                    e = expected_events.pop_front();
                    if (event_res !== e.ev)
                        report($sformatf("event %0d want %0d", event_res, e.ev));
                    if (node_id !== e.id) report($sformatf("id %h want %h", node_id, e.id));
                    if (node_port !== e.port)
                        report($sformatf("port %h want %h", node_port, e.port));
                    if (node_heartbeat !== e.beat)
                        report($sformatf("beat %h want %h", node_heartbeat, e.beat));
                    if (last !== e.last) report($sformatf("last %b want %b", last, e.last));
                end
            end
            res_stall <= hold_results || ($urandom_range(99) < stall_pct);
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_AW'(idx) << 2; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_SELF_ID:     cf_self_id = val;
            REG_SELF_PORT:   cf_self_port = val[15:0];
            REG_FAIL_TIME:   cf_fail = val[15:0];
            REG_REMOVE_TIME: cf_remove = val[15:0];
            default:         cf_intro = val[0];
        endcase
    endtask

    task automatic drain();
        while (pending_entries.size() > 0 || item_valid || expected_events.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic entry_t mk(input logic [1:0] k, input logic [31:0] id,
                                  input logic [15:0] p, input logic [31:0] b, input logic e);
        mk = '{k, id, p, b, e};
    endfunction

    // mostly well-formed traffic over a small id pool, some noise
    task automatic queue_random(input int n, input int pool);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 30)
                queue_entry(mk(KIND_TICK, $urandom, 16'($urandom), $urandom, 1'($urandom)));
            else if (r < 85)
                queue_entry(mk(KIND_GOSSIP, 32'h100 + $urandom_range(pool),
                    16'(i % 2), $urandom_range(20), 1'b0));
            else if (r < 93)
                queue_entry(mk(KIND_JOIN, 32'h100 + $urandom_range(pool), 16'd0,
                    $urandom, 1'($urandom_range(1))));
            else if (r < 97)
                queue_entry(mk(2'(r % 2), $urandom, 16'($urandom), $urandom,
                    1'($urandom)));
            else
                queue_entry(mk(2'd3, $urandom, 16'($urandom), $urandom, 1'($urandom)));
        end
    endtask

    initial
    begin
        cf_self_id = '0; cf_self_port = '0; cf_fail = 16'd5; cf_remove = 16'd20;
        cf_intro = 1'b0; now = '0; has_joined = 1'b0;
        for (int i = 0; i < MSLOTS; i++) m_vld[i] = 1'b0;
        for (int j = 0; j < SSLOTS; j++) s_vld[j] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        cfg_write(REG_SELF_ID, 32'hFFFF_FFFF);
        cfg_write(REG_SELF_PORT, 32'h0000_FFFF);
        cfg_write(REG_FAIL_TIME, 32'd2);
        cfg_write(REG_REMOVE_TIME, 32'd4);
        cfg_write(REG_INTRODUCER, 32'd0);

        // directed: extremes, self, not joined, join, refresh, stale
        queue_entry(mk(KIND_GOSSIP, 32'h0, 16'h0, 32'h0, 1'b0));
        queue_entry(mk(KIND_GOSSIP, 32'hFFFF_FFFF, 16'hFFFF, 32'h5, 1'b1));
        queue_entry(mk(KIND_GOSSIP, 32'hFFFF_FFFF, 16'hFFFE, 32'hFFFF_FFFF, 1'b0));
        queue_entry(mk(KIND_GOSSIP, 32'h0, 16'h0, 32'h0, 1'b0));
        queue_entry(mk(KIND_GOSSIP, 32'h0, 16'h0, 32'h7, 1'b0));
        queue_entry(mk(KIND_TICK, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        queue_entry(mk(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        queue_entry(mk(KIND_JOIN, 32'hFFFF_FFFF, 16'hFFFF, 32'h1, 1'b0));
        queue_entry(mk(KIND_JOIN, 32'h0, 16'h0, 32'h9, 1'b0));
        queue_entry(mk(KIND_JOIN, 32'h55, 16'h1, 32'h3, 1'b1));
        for (int t = 0; t < 4; t++)
            queue_entry(mk(KIND_TICK, '0, '0, '0, 1'b0));
        queue_entry(mk(KIND_JOIN, 32'h0, 16'h0, 32'h2, 1'b0));
        for (int t = 0; t < 5; t++)
            queue_entry(mk(KIND_TICK, '0, '0, '0, 1'b0));
        drain();

        // fill the member table past capacity, then let all go stale at once
        for (int i = 0; i < 34; i++)
            queue_entry(mk(KIND_GOSSIP, 32'h8000_0000 + i, 16'(i), i, 1'b0));
        // long receiver hold-off while items keep coming
        hold_results = 1'b1;
        repeat (3000) @(posedge clk);
        hold_results = 1'b0;
        drain();
        cfg_write(REG_REMOVE_TIME, 32'd60);
        for (int i = 0; i < 34; i++)
            queue_entry(mk(KIND_JOIN, 32'h9000_0000 + i, 16'(i), i, 1'b0));
        for (int t = 0; t < 3; t++) queue_entry(mk(KIND_TICK, '0, '0, '0, 1'b0));
        drain();
        for (int i = 0; i < 34; i++)
            queue_entry(mk(KIND_GOSSIP, 32'hA000_0000 + i, 16'(i), i, 1'b0));
        for (int t = 0; t < 3; t++) queue_entry(mk(KIND_TICK, '0, '0, '0, 1'b0));
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            cfg_write(REG_FAIL_TIME, ph == 3 ? 32'hFFFF : $urandom_range(6));
            cfg_write(REG_REMOVE_TIME, ph == 2 ? 32'd0 : $urandom_range(12));
            cfg_write(REG_INTRODUCER, ph % 2);
            cfg_write(REG_SELF_ID, 32'h100 + ph);
            cfg_write(REG_SELF_PORT, 32'd0);
            queue_random(38, 24);
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== heartbeat_membership_table.f =====
src/hmt_pkg.sv
src/hmt_member_cell.sv
src/hmt_suspect_cell.sv
src/heartbeat_membership_table.sv
tb/tb_top.sv
